### hw/rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text console writer
// Screen geometry, character codes and the microcode store that sequences
// every put, read, scroll and clear operation.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int CELLS     = COLUMNS * ROWS;
    localparam int ADDR_W    = $clog2(CELLS);
    localparam int CUR_W     = $clog2(CELLS + COLUMNS);
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int CELL_W    = 16;
    localparam int TAB_STEP  = 4;

    // Field widths of the item and result beats
    localparam int CHAR_W    = 8;
    localparam int ATTR_W    = 8;
    localparam int INDEX_W   = 11;
    localparam int CURSOR_W  = 11;

    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NL    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_BLANK = 8'h20;

    // Item opcodes
    localparam logic OP_PUT  = 1'b0;
    localparam logic OP_READ = 1'b1;

    // Microcode step addresses
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] S_CLR      = 4'd0;
    localparam logic [STEP_W-1:0] S_IDLE     = 4'd1;
    localparam logic [STEP_W-1:0] S_DISP     = 4'd2;
    localparam logic [STEP_W-1:0] S_PUT      = 4'd3;
    localparam logic [STEP_W-1:0] S_CHK      = 4'd4;
    localparam logic [STEP_W-1:0] S_SCR_RD   = 4'd5;
    localparam logic [STEP_W-1:0] S_SCR_MV   = 4'd6;
    localparam logic [STEP_W-1:0] S_SCR_FILL = 4'd7;
    localparam logic [STEP_W-1:0] S_EMIT     = 4'd8;
    localparam logic [STEP_W-1:0] S_READ     = 4'd9;
    localparam logic [STEP_W-1:0] S_BS_RD    = 4'd10;
    localparam logic [STEP_W-1:0] S_BS_WR    = 4'd11;

    // Jump conditions: jump to target when true, else advance one step
    localparam logic [2:0] C_NEXT         = 3'd0;
    localparam logic [2:0] C_ALWAYS       = 3'd1;
    localparam logic [2:0] C_NO_ITEM      = 3'd2;
    localparam logic [2:0] C_IS_READ      = 3'd3;
    localparam logic [2:0] C_IS_BS        = 3'd4;
    localparam logic [2:0] C_NO_SCROLL    = 3'd5;
    localparam logic [2:0] C_ADDR_NOT_END = 3'd6;
    localparam logic [2:0] C_MOVE_NOT_END = 3'd7;

    // Store write selects
    localparam logic [2:0] W_NONE  = 3'd0;
    localparam logic [2:0] W_ZERO  = 3'd1;
    localparam logic [2:0] W_PUT   = 3'd2;
    localparam logic [2:0] W_BS    = 3'd3;
    localparam logic [2:0] W_MOVE  = 3'd4;
    localparam logic [2:0] W_BLANK = 3'd5;

    // Store read selects
    localparam logic [2:0] R_NONE     = 3'd0;
    localparam logic [2:0] R_INDEX    = 3'd1;
    localparam logic [2:0] R_CUR      = 3'd2;
    localparam logic [2:0] R_SRC      = 3'd3;
    localparam logic [2:0] R_SRC_NEXT = 3'd4;

    // Cursor operations
    localparam logic [1:0] U_HOLD   = 2'd0;
    localparam logic [1:0] U_PUT    = 2'd1;
    localparam logic [1:0] U_SCROLL = 2'd2;

    // Sweep address operations
    localparam logic [1:0] A_HOLD = 2'd0;
    localparam logic [1:0] A_ZERO = 2'd1;
    localparam logic [1:0] A_INC  = 2'd2;

    typedef struct packed {
        logic [2:0]        cond;
        logic [STEP_W-1:0] target;
        logic              accept;
        logic [2:0]        wr_sel;
        logic [2:0]        rd_sel;
        logic [1:0]        cur_op;
        logic [1:0]        addr_op;
        logic              scr_load;
        logic              emit;
    } ucode_t;

    // Control store. Field order: cond, target, accept, wr_sel, rd_sel,
    // cur_op, addr_op, scr_load, emit.
    function automatic ucode_t micro_rom(input logic [STEP_W-1:0] step);
        ucode_t uw;
        case (step)
            S_CLR:      uw = '{C_ADDR_NOT_END, S_CLR, 1'b0, W_ZERO, R_NONE,
                               U_HOLD, A_INC, 1'b0, 1'b0};
            S_IDLE:     uw = '{C_NO_ITEM, S_IDLE, 1'b1, W_NONE, R_NONE,
                               U_HOLD, A_HOLD, 1'b0, 1'b0};
            S_DISP:     uw = '{C_IS_READ, S_READ, 1'b0, W_NONE, R_NONE,
                               U_HOLD, A_HOLD, 1'b0, 1'b0};
            S_PUT:      uw = '{C_IS_BS, S_BS_RD, 1'b0, W_PUT, R_NONE,
                               U_PUT, A_HOLD, 1'b0, 1'b0};
            S_CHK:      uw = '{C_NO_SCROLL, S_EMIT, 1'b0, W_NONE, R_NONE,
                               U_HOLD, A_ZERO, 1'b1, 1'b0};
            S_SCR_RD:   uw = '{C_NEXT, S_CLR, 1'b0, W_NONE, R_SRC,
                               U_SCROLL, A_HOLD, 1'b0, 1'b0};
            S_SCR_MV:   uw = '{C_MOVE_NOT_END, S_SCR_MV, 1'b0, W_MOVE, R_SRC_NEXT,
                               U_HOLD, A_INC, 1'b0, 1'b0};
            S_SCR_FILL: uw = '{C_ADDR_NOT_END, S_SCR_FILL, 1'b0, W_BLANK, R_NONE,
                               U_HOLD, A_INC, 1'b0, 1'b0};
            S_EMIT:     uw = '{C_ALWAYS, S_IDLE, 1'b0, W_NONE, R_NONE,
                               U_HOLD, A_HOLD, 1'b0, 1'b1};
            S_READ:     uw = '{C_ALWAYS, S_EMIT, 1'b0, W_NONE, R_INDEX,
                               U_HOLD, A_HOLD, 1'b0, 1'b0};
            S_BS_RD:    uw = '{C_NEXT, S_CLR, 1'b0, W_NONE, R_CUR,
                               U_HOLD, A_HOLD, 1'b0, 1'b0};
            S_BS_WR:    uw = '{C_ALWAYS, S_EMIT, 1'b0, W_BS, R_NONE,
                               U_HOLD, A_HOLD, 1'b0, 1'b0};
            default:    uw = '{C_ALWAYS, S_IDLE, 1'b0, W_NONE, R_NONE,
                               U_HOLD, A_HOLD, 1'b0, 1'b0};
        endcase
        return uw;
    endfunction

endpackage

### hw/rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: 80 x 25 character-cell text console
// A microcoded sequencer steps through a small control store and drives
// the cursor logic and a single screen RAM of character/attribute cells.
// ----------------------------------------------------------------------------
// Steps per item: put = dispatch, put, check, emit; backspace = dispatch,
// put, read, write, emit; read = dispatch, read, emit. One item is in
// work at a time, so the next item beat is taken only once the last
// result beat has been emitted. A put that scrolls adds a move loop that
// copies one cell per cycle through the single RAM write port, then the
// bottom row fill. Reset: cursor 0, attribute 7, then a clearing pass
// zeroes the screen RAM before the first item beat is taken.
// ----------------------------------------------------------------------------
module text_console_writer (
    input  logic                          clk,
    input  logic                          rst_n,

    // Configuration: text attribute register
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tcw_pkg::ATTR_W-1:0]    cfg_data,

    // Item channel
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          opcode,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::INDEX_W-1:0]   cell_index,

    // Result channel
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [tcw_pkg::CHAR_W-1:0]    echoed_char,
    output logic [tcw_pkg::CURSOR_W-1:0]  cursor_cell,
    output logic                          scrolled,
    output logic [tcw_pkg::CHAR_W-1:0]    read_char,
    output logic [tcw_pkg::ATTR_W-1:0]    read_attr
);

    import tcw_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] MOVE_END  = ADDR_W'(CELLS - COLUMNS - 1);

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic [STEP_W-1:0] upc_reg, upc_next;
    ucode_t            ctl;
    logic              cond_true;
    logic              stall;
    logic              accept;

    // Item latch
    logic              opcode_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [INDEX_W-1:0] index_reg;
    logic              index_ok;
    logic              is_ctrl;

    // Datapath state
    logic [ATTR_W-1:0] attr_reg, attr_next;
    logic [CUR_W-1:0]  cursor_reg, cursor_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic              scroll_reg, scroll_next;
    logic              need_scroll;

    // Cursor arithmetic
    logic [CUR_W-1:0]  row_start;
    logic [COL_W:0]    col_plus1, col_plus_tab;

    // Screen RAM ports
    logic              wr_en, rd_en;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [CELL_W-1:0] wr_data, rd_data;

    // Result register
    logic                out_valid_reg, out_valid_next;
    logic                emit_fire;
    logic [CHAR_W-1:0]   echoed_reg;
    logic [CURSOR_W-1:0] cursor_out_reg;
    logic                scrolled_reg;
    logic [CHAR_W-1:0]   rchar_reg;
    logic [ATTR_W-1:0]   rattr_reg;

    assign ctl      = micro_rom(upc_reg);
    assign in_ready = ctl.accept;
    assign accept   = in_valid && in_ready;
    assign cfg_ready = 1'b1;

    assign is_ctrl     = char_reg inside {CH_NL, CH_CR, CH_TAB, CH_BS};
    assign index_ok    = index_reg < INDEX_W'(CELLS);
    assign need_scroll = cursor_reg >= CUR_W'(CELLS);

    // Hold the step while a finished result still waits to be taken
    assign stall     = ctl.emit && out_valid_reg && !out_ready;
    assign emit_fire = ctl.emit && !stall;

    always_comb
    begin
        case (ctl.cond)
            C_NEXT:         cond_true = 1'b0;
            C_ALWAYS:       cond_true = 1'b1;
            C_NO_ITEM:      cond_true = !in_valid;
            C_IS_READ:      cond_true = (opcode_reg == OP_READ);
            C_IS_BS:        cond_true = (char_reg == CH_BS);
            C_NO_SCROLL:    cond_true = !need_scroll;
            C_ADDR_NOT_END: cond_true = (addr_reg != LAST_CELL);
            C_MOVE_NOT_END: cond_true = (addr_reg != MOVE_END);
            default:        cond_true = 1'b0;
        endcase
    end

    always_comb
    begin
        if (stall)
        begin
            upc_next = upc_reg;
        end
        else if (cond_true)
        begin
            upc_next = ctl.target;
        end
        else
        begin
            upc_next = upc_reg + 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Cursor: linear cell index plus its column, kept in step so that the
    // row start is a plain subtract
    // ------------------------------------------------------------------
    assign row_start    = cursor_reg - CUR_W'(col_reg);
    assign col_plus1    = {1'b0, col_reg} + (COL_W+1)'(1);
    assign col_plus_tab = {1'b0, col_reg} + (COL_W+1)'(TAB_STEP);

    always_comb
    begin
        cursor_next = cursor_reg;
        col_next    = col_reg;
        case (ctl.cur_op)
            U_PUT:
            begin
                case (char_reg)
                    CH_NL:
                    begin
                        cursor_next = row_start + CUR_W'(COLUMNS);
                        col_next    = '0;
                    end
                    CH_CR:
                    begin
                        cursor_next = row_start;
                        col_next    = '0;
                    end
                    CH_TAB:
                    begin
                        cursor_next = cursor_reg + CUR_W'(TAB_STEP);
                        if (col_plus_tab >= (COL_W+1)'(COLUMNS))
                        begin
                            col_next = COL_W'(col_plus_tab - (COL_W+1)'(COLUMNS));
                        end
                        else
                        begin
                            col_next = col_plus_tab[COL_W-1:0];
                        end
                    end
                    CH_BS:
                    begin
                        // Saturate at the first cell
                        if (cursor_reg != '0)
                        begin
                            cursor_next = cursor_reg - 1'b1;
                            if (col_reg == '0)
                            begin
                                col_next = COL_W'(COLUMNS - 1);
                            end
                            else
                            begin
                                col_next = col_reg - 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        cursor_next = cursor_reg + 1'b1;
                        if (col_plus1 >= (COL_W+1)'(COLUMNS))
                        begin
                            col_next = '0;
                        end
                        else
                        begin
                            col_next = col_plus1[COL_W-1:0];
                        end
                    end
                endcase
            end
            U_SCROLL:
            begin
                // Move back one row; the column is unchanged
                cursor_next = cursor_reg - CUR_W'(COLUMNS);
            end
            default:
            begin
                cursor_next = cursor_reg;
                col_next    = col_reg;
            end
        endcase
    end

    // Sweep address for the clearing pass and the scroll loops
    always_comb
    begin
        case (ctl.addr_op)
            A_ZERO:  addr_next = '0;
            A_INC:   addr_next = addr_reg + 1'b1;
            default: addr_next = addr_reg;
        endcase
    end

    always_comb
    begin
        scroll_next = scroll_reg;
        if (accept)
        begin
            scroll_next = 1'b0;
        end
        else if (ctl.scr_load)
        begin
            scroll_next = need_scroll;
        end
    end

    assign attr_next = (cfg_valid && cfg_ready) ? cfg_data : attr_reg;

    // ------------------------------------------------------------------
    // Screen RAM access
    // ------------------------------------------------------------------
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = '0;
        case (ctl.wr_sel)
            W_ZERO:
            begin
                wr_en = 1'b1;
            end
            W_PUT:
            begin
                // Control codes NL, CR, TAB and BS never land in the store
                wr_en   = !is_ctrl;
                wr_addr = cursor_reg[ADDR_W-1:0];
                wr_data = {attr_reg, char_reg};
            end
            W_BS:
            begin
                // Keep the attribute, blank the character
                wr_en   = 1'b1;
                wr_addr = cursor_reg[ADDR_W-1:0];
                wr_data = {rd_data[CELL_W-1:CHAR_W], CH_BLANK};
            end
            W_MOVE:
            begin
                wr_en   = 1'b1;
                wr_data = rd_data;
            end
            W_BLANK:
            begin
                wr_en   = 1'b1;
                wr_data = {attr_reg, CH_BLANK};
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = addr_reg;
        case (ctl.rd_sel)
            R_INDEX:
            begin
                rd_en   = index_ok;
                rd_addr = index_reg[ADDR_W-1:0];
            end
            R_CUR:
            begin
                rd_en   = 1'b1;
                rd_addr = cursor_reg[ADDR_W-1:0];
            end
            R_SRC:
            begin
                rd_en   = 1'b1;
                rd_addr = addr_reg + ADDR_W'(COLUMNS);
            end
            R_SRC_NEXT:
            begin
                // Fetch the next move's source; drop it on the last move
                rd_en   = (addr_reg != MOVE_END);
                rd_addr = addr_reg + ADDR_W'(COLUMNS + 1);
            end
            default:
            begin
                rd_en = 1'b0;
            end
        endcase
    end

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ------------------------------------------------------------------
    // Result beat
    // ------------------------------------------------------------------
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg       <= S_CLR;
            attr_reg      <= ATTR_RESET;
            cursor_reg    <= '0;
            col_reg       <= '0;
            addr_reg      <= '0;
            scroll_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            upc_reg       <= upc_next;
            attr_reg      <= attr_next;
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            addr_reg      <= addr_next;
            scroll_reg    <= scroll_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Item and result payload, no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            opcode_reg <= opcode;
            char_reg   <= char_code;
            index_reg  <= cell_index;
        end
        if (emit_fire)
        begin
            cursor_out_reg <= cursor_reg[CURSOR_W-1:0];
            if (opcode_reg == OP_READ)
            begin
                echoed_reg   <= '0;
                scrolled_reg <= 1'b0;
                rchar_reg    <= index_ok ? rd_data[CHAR_W-1:0] : '0;
                rattr_reg    <= index_ok ? rd_data[CELL_W-1:CHAR_W] : '0;
            end
            else
            begin
                echoed_reg   <= char_reg;
                scrolled_reg <= scroll_reg;
                rchar_reg    <= '0;
                rattr_reg    <= '0;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign echoed_char = echoed_reg;
    assign cursor_cell = cursor_out_reg;
    assign scrolled    = scrolled_reg;
    assign read_char   = rchar_reg;
    assign read_attr   = rattr_reg;

endmodule

### hw/rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### dv/tb_text_console_writer.sv
// ----------------------------------------------------------------------------
// tb_text_console_writer: self-checking bench for the text console writer
// Drives put and read beats into the console. A shadow copy of the screen,
// the cursor and the attribute register predicts every result beat, and
// each result beat is compared field by field. Both sides idle at random,
// the receiver holds off once for a long stretch, and the attribute register
// is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_text_console_writer;

    import tcw_pkg::*;

    // Run shape
    localparam int RANDOM_ITEMS  = 2000;
    localparam int PHASES        = 6;
    localparam int LONG_HOLD     = 400;
    localparam int STALL_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 8;
    localparam int INDEX_TOP     = (1 << INDEX_W) - 1;

    // Receiver stall patterns
    typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PERIODIC} ready_mode_t;

    // One result beat as the console should report it
    typedef struct {
        logic [CHAR_W-1:0]   echoed_char;
        logic [CURSOR_W-1:0] cursor_cell;
        logic                scrolled;
        logic [CHAR_W-1:0]   read_char;
        logic [ATTR_W-1:0]   read_attr;
    } console_result_t;

    // DUT ports; every input starts at a known value
    logic                clk        = 1'b0;
    logic                rst_n      = 1'b0;
    logic                cfg_valid  = 1'b0;
    logic                cfg_ready;
    logic [ATTR_W-1:0]   cfg_data   = '0;
    logic                in_valid   = 1'b0;
    logic                in_ready;
    logic                opcode     = OP_PUT;
    logic [CHAR_W-1:0]   char_code  = '0;
    logic [INDEX_W-1:0]  cell_index = '0;
    logic                out_valid;
    logic                out_ready  = 1'b0;
    logic [CHAR_W-1:0]   echoed_char;
    logic [CURSOR_W-1:0] cursor_cell;
    logic                scrolled;
    logic [CHAR_W-1:0]   read_char;
    logic [ATTR_W-1:0]   read_attr;

    // Shadow state of the console: cell = {attribute, character}
    logic [CELL_W-1:0]   screen_image [CELLS];
    int                  cursor_now;
    logic [ATTR_W-1:0]   attr_now;

    // Predicted result beats, oldest first
    console_result_t     pending_results [$];

    int                  fail_count    = 0;
    int                  idle_cycles   = 0;

    // Sender burst control
    int                  burst_left    = 0;
    bit                  sender_steady = 1'b0;

    // Receiver control; the test bumps hold_asked to request one long hold
    int                  hold_asked    = 0;
    int                  hold_served   = 0;
    int                  hold_left     = 0;
    int                  mode_left     = 0;
    int                  pattern_phase = 0;
    ready_mode_t         ready_mode    = READY_ALWAYS;

    text_console_writer dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .char_code   (char_code),
        .cell_index  (cell_index),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .echoed_char (echoed_char),
        .cursor_cell (cursor_cell),
        .scrolled    (scrolled),
        .read_char   (read_char),
        .read_attr   (read_attr)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------------
    // Predictor: apply one accepted item to the shadow state and queue the
    // result beat it must produce.
    // ------------------------------------------------------------------------
    task automatic console_step_predict(input logic op, input logic [CHAR_W-1:0] ch,
                                        input logic [INDEX_W-1:0] idx);
        console_result_t r;
        int cur;
        int k;
        r = '{default: '0};
        cur = cursor_now;
        // Treat an out-of-range cursor as home
        if (cur >= CELLS)
            cur = 0;
        if (op == OP_READ)
        begin
            // Out-of-range reads return zeros and change nothing
            if (idx < CELLS)
            begin
                r.read_char = screen_image[idx][CHAR_W-1:0];
                r.read_attr = screen_image[idx][CELL_W-1:CHAR_W];
            end
        end
        else
        begin
            r.echoed_char = ch;
            case (ch)
                CH_NL:   cur = (cur / COLUMNS) * COLUMNS + COLUMNS;
                CH_CR:   cur = (cur / COLUMNS) * COLUMNS;
                CH_TAB:  cur = cur + TAB_STEP;
                CH_BS:
                begin
                    // Step back, saturate at home, blank the char, keep the attribute
                    if (cur > 0)
                        cur = cur - 1;
                    screen_image[cur][CHAR_W-1:0] = CH_BLANK;
                end
                default:
                begin
                    screen_image[cur] = {attr_now, ch};
                    cur = cur + 1;
                end
            endcase
            // Past the last cell: shift every row up, blank the bottom row
            if (cur >= CELLS)
            begin
                for (k = 0; k < CELLS - COLUMNS; k++)
                    screen_image[k] = screen_image[k + COLUMNS];
                for (k = CELLS - COLUMNS; k < CELLS; k++)
                    screen_image[k] = {attr_now, CH_BLANK};
                cur = cur - COLUMNS;
                r.scrolled = 1'b1;
            end
            cursor_now = cur;
        end
        r.cursor_cell = CURSOR_W'(cursor_now);
        pending_results.push_back(r);
    endtask

    // ------------------------------------------------------------------------
    // Sender: offer one item beat, hold it until accepted, then either keep
    // valid up for the next beat or drop it for a random gap between bursts.
    // ------------------------------------------------------------------------
    task automatic send_item(input logic op, input logic [CHAR_W-1:0] ch,
                             input logic [INDEX_W-1:0] idx);
        int gap;
        in_valid   <= 1'b1;
        opcode     <= op;
        char_code  <= ch;
        cell_index <= idx;
        do @(posedge clk); while (!in_ready);
        console_step_predict(op, ch, idx);
        if (!sender_steady)
        begin
            if (burst_left > 0)
            begin
                burst_left--;
            end
            else
            begin
                burst_left = $urandom_range(0, 15);
                gap = $urandom_range(1, 6);
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // Draw one item: mostly puts heavy on control codes so the screen fills
    // and scrolls, and reads that favor the cells around the cursor.
    task automatic send_random_item();
        logic [CHAR_W-1:0]  ch;
        logic [INDEX_W-1:0] idx;
        int pick;
        int near;
        ch  = CHAR_W'($urandom_range(0, 255));
        idx = INDEX_W'($urandom_range(0, INDEX_TOP));
        if ($urandom_range(0, 99) < 45)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                idx = INDEX_W'($urandom_range(CELLS, INDEX_TOP));
            end
            else if (pick < 3)
            begin
                idx = INDEX_W'($urandom_range(0, INDEX_TOP));
            end
            else if (pick < 6)
            begin
                near = $urandom_range(0, 6);
                idx = (cursor_now >= near) ? INDEX_W'(cursor_now - near) : '0;
            end
            else
            begin
                idx = INDEX_W'($urandom_range(0, CELLS - 1));
            end
            send_item(OP_READ, ch, idx);
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                ch = CH_NL;
            else if (pick < 11)
                ch = CH_CR;
            else if (pick < 16)
                ch = CH_TAB;
            else if (pick < 24)
                ch = CH_BS;
            send_item(OP_PUT, ch, idx);
        end
    endtask

    // Drop valid, wait for every predicted beat, then let the sequencer settle
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the attribute register; call only while the console is idle
    task automatic write_text_attribute(input logic [ATTR_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        attr_now = value;
        cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // The end cells and out-of-range indices must read zero after the clearing pass
    task automatic test_cleared_screen();
        send_item(OP_READ, 8'hFF, '0);
        send_item(OP_READ, 8'h00, INDEX_W'(CELLS - 1));
        send_item(OP_READ, 8'hAA, INDEX_W'(CELLS));
        send_item(OP_READ, 8'h55, INDEX_W'(INDEX_TOP));
        wait_results_drained();
    endtask

    // Field extremes and every control code, including backspace at home
    task automatic test_control_codes();
        send_item(OP_PUT, 8'h00, INDEX_W'(INDEX_TOP));
        send_item(OP_PUT, 8'hFF, '0);
        send_item(OP_PUT, 8'h41, '0);
        send_item(OP_PUT, CH_BS, '0);
        send_item(OP_PUT, CH_CR, '0);
        send_item(OP_PUT, CH_BS, '0);
        send_item(OP_PUT, CH_TAB, '0);
        send_item(OP_PUT, CH_NL, '0);
        send_item(OP_READ, 8'h00, INDEX_W'(0));
        send_item(OP_READ, 8'h00, INDEX_W'(1));
        send_item(OP_READ, 8'h00, INDEX_W'(2));
        wait_results_drained();
    endtask

    // Walk the cursor to the bottom row, then push it past the last cell
    task automatic test_scroll_up();
        write_text_attribute(8'hFF);
        while (cursor_now < CELLS - COLUMNS)
            send_item(OP_PUT, CH_NL, '0);
        send_item(OP_PUT, 8'h5A, '0);
        send_item(OP_PUT, CH_NL, '0);
        send_item(OP_READ, 8'h00, INDEX_W'(CELLS - 2 * COLUMNS));
        send_item(OP_READ, 8'h00, INDEX_W'(CELLS - COLUMNS));
        send_item(OP_READ, 8'h00, INDEX_W'(CELLS - 1));
        wait_results_drained();
    endtask

    // Hold the receiver off while the sender keeps offering beats
    task automatic test_backpressure();
        int n;
        sender_steady = 1'b1;
        hold_asked++;
        for (n = 0; n < 30; n++)
            send_random_item();
        sender_steady = 1'b0;
        wait_results_drained();
    endtask

    // Random traffic in phases, each under its own attribute setting
    task automatic test_random_traffic();
        logic [ATTR_W-1:0] phase_attr [PHASES];
        logic [ATTR_W-1:0] attr;
        int phase;
        int n;
        phase_attr = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h80, 8'h07};
        for (phase = 0; phase < PHASES; phase++)
        begin
            attr = (phase == 4) ? ATTR_W'($urandom_range(0, 255)) : phase_attr[phase];
            write_text_attribute(attr);
            // Run every third phase with no sender gaps
            sender_steady = (phase % 3 == 0);
            for (n = 0; n < RANDOM_ITEMS / PHASES; n++)
                send_random_item();
            sender_steady = 1'b0;
            wait_results_drained();
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence: reset once, then the tests in turn, then the verdict
    // ------------------------------------------------------------------------
    initial
    begin
        foreach (screen_image[i])
            screen_image[i] = '0;
        cursor_now = 0;
        attr_now   = ATTR_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_cleared_screen();
        test_control_codes();
        test_scroll_up();
        test_backpressure();
        test_random_traffic();
        wait_results_drained();

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: a long hold when the test asks for one, otherwise stall on a
    // pattern that is redrawn at random whenever its run ends.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (hold_served != hold_asked)
        begin
            hold_served = hold_asked;
            hold_left   = LONG_HOLD;
            out_ready <= 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                ready_mode = ready_mode_t'($urandom_range(0, 2));
                mode_left  = $urandom_range(50, 400);
            end
            else
            begin
                mode_left--;
            end
            case (ready_mode)
                READY_ALWAYS:   out_ready <= 1'b1;
                READY_RANDOM:   out_ready <= ($urandom_range(0, 3) != 0);
                default:
                begin
                    pattern_phase++;
                    out_ready <= ((pattern_phase % 5) < 2);
                end
            endcase
        end
    end

    // Report one field that differs from its prediction
    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result check: compare each accepted result beat with the oldest
    // prediction.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        console_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("%0t: result beat with no prediction pending", $time);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("echoed_char", 16'(want.echoed_char), 16'(echoed_char));
                check_field("cursor_cell", 16'(want.cursor_cell), 16'(cursor_cell));
                check_field("scrolled", 16'(want.scrolled), 16'(scrolled));
                check_field("read_char", 16'(want.read_char), 16'(read_char));
                check_field("read_attr", 16'(want.read_attr), 16'(read_attr));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: count cycles with no beat on any channel. The limit covers
    // the clearing pass, a scroll and the long receiver hold together.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no beat for %0d cycles", $time, STALL_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

endmodule

### files.f
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ram.sv
hw/rtl/text_console_writer.sv
dv/tb_text_console_writer.sv
